[src/rtdat_pkg.sv]
// ============================================================================
// rtdat_pkg: shared constants and types for the RTD temperature unit
// Field widths, sensor-curve coefficients in fixed point, operation codes,
// register indexes and the side-band record that travels down the pipeline.
// ============================================================================
`default_nettype none

package rtdat_pkg;

  // Channel count and converter resolution
  localparam int NUM_CHANNELS = 12;
  localparam int ADC_BITS     = 12;

  // Field widths
  localparam int CH_W     = 4;
  localparam int SAMPLE_W = 12;
  localparam int GAIN_W   = 16;
  localparam int TEMP_W   = 24;

  // Configuration port
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_THRESH = '0;

  // Operation codes
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  // Reset values
  localparam int THRESH_RST = 130560;
  localparam int GAIN_UNITY = 4096;

  // Sensor curve V = a*T^2 + b*T + c, scaled coefficients
  localparam longint unsigned COEF_A   = 60154;
  localparam longint unsigned COEF_B   = 94526;
  localparam longint unsigned COEF_C   = 20988;
  localparam int              RTD_FRAC = 22;

  // Radicand N = K0 - (K1 * x) << K1_SH, always positive and below 2^62
  localparam longint unsigned BASE_N = 100 * COEF_B * COEF_B + 4 * COEF_A * COEF_C;
  localparam longint unsigned K0_V   = BASE_N << RTD_FRAC;
  localparam longint unsigned K1_V   = 13200000 * COEF_A;
  localparam int              K1_W   = 40;
  localparam int              K1_SH  = RTD_FRAC - ADC_BITS;
  localparam int              PROD_W = K1_W + ADC_BITS;
  localparam int              N_W    = 62;

  // Square root: one result bit per stage
  localparam int SQ_STEPS = N_W / 2;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = SQ_STEPS + 2;

  // Root to temperature: round((T_OFS - s) * 25 / (4*A)), ties away from zero
  localparam longint unsigned T_OFS     = 20480 * COEF_B;
  localparam longint unsigned NUM_SCALE = 25;
  localparam longint unsigned DEN_HALF  = 2 * COEF_A;
  localparam longint unsigned DEN_SUB   = COEF_A / 2;   // 4*A / 8
  localparam int              DEN_SH    = 3;
  localparam int              DEN_SUB_W = 15;
  localparam int              D_W       = ROOT_W + 2;
  localparam int              MAGF_W    = 36;
  localparam int              MAG_W     = MAGF_W - DEN_SH;
  localparam longint unsigned RECIP     = (64'd1 << MAG_W) / DEN_SUB;
  localparam int              RECIP_W   = 19;
  localparam int              QEST_W    = 19;
  localparam int              QD_W      = QEST_W + DEN_SUB_W;
  localparam int              T_W       = 20;

  // Calibration: Q4.12 gain, round half up, then offset
  localparam int GAIN_FRAC = 12;
  localparam int P_W       = GAIN_W + T_W;
  localparam int R_W       = 26;

  // Per-item record carried alongside the datapath
  typedef struct packed {
    logic        [CH_W-1:0]   ch;
    logic signed [GAIN_W-1:0] gain;
    logic signed [TEMP_W-1:0] offset;
  } side_t;

endpackage

`default_nettype wire

[src/rtd_adc_to_temperature_unit.sv]
// ============================================================================
// rtd_adc_to_temperature_unit: ADC code to calibrated RTD temperature
// Pipelined inversion of a quadratic sensor curve through a square root,
// followed by per-channel gain and offset and a disconnect check.
// ============================================================================
// The unit takes one request per clock while the skid entry is empty. A
// convert request (operation 0) on a channel below NUM_CHANNELS yields one
// result. The edge that accepts it loads the first of 40 registers: 2 stages
// form the radicand, 31 stages each resolve one bit of the square root, 4
// stages turn the root into degrees by a reciprocal multiply, 2 stages apply
// the gain and offset, and the output register saturates and compares
// against the threshold. The 31-stage square root is most of the pipeline.
// A load request (operation 1) writes the channel's gain and offset at the
// accepting edge and is seen by every convert accepted after it; loads and
// converts on channels at or above NUM_CHANNELS give no result. A two-entry
// output (register plus skid) takes one more result after the consumer stalls.
// The threshold register sits at address 0 of the configuration port and
// should only be written while the unit is drained.
// ============================================================================
`default_nettype none

module rtd_adc_to_temperature_unit
  import rtdat_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  // Request channel
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      in_operation,
  input  wire        [CH_W-1:0]    in_channel,
  input  wire        [SAMPLE_W-1:0] in_sample,
  input  wire signed [GAIN_W-1:0]  in_gain,
  input  wire signed [TEMP_W-1:0]  in_offset,
  // Result channel
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic       [CH_W-1:0]    out_channel,
  output logic signed [TEMP_W-1:0] out_temperature,
  output logic                     out_reading_valid,
  // Configuration port
  input  wire                      cfg_psel,
  input  wire                      cfg_penable,
  input  wire                      cfg_pwrite,
  input  wire        [CFG_AW-1:0]  cfg_paddr,
  input  wire        [CFG_DW-1:0]  cfg_pwdata,
  output logic       [CFG_DW-1:0]  cfg_prdata,
  output logic                     cfg_pready
);

  // Stage positions
  localparam int ST_PROD = 0;
  localparam int ST_N    = 1;
  localparam int ST_SQ0  = 2;
  localparam int ST_D1   = ST_SQ0 + SQ_STEPS;
  localparam int ST_D2   = ST_D1 + 1;
  localparam int ST_D3   = ST_D2 + 1;
  localparam int ST_D4   = ST_D3 + 1;
  localparam int ST_G1   = ST_D4 + 1;
  localparam int ST_G2   = ST_G1 + 1;
  localparam int NST     = ST_G2 + 1;

  localparam int CH_IDX_W = $clog2(NUM_CHANNELS);
  localparam int QP_W     = MAG_W + RECIP_W;

  localparam logic signed [R_W-1:0] SAT_HI = R_W'((64'd1 << (TEMP_W - 1)) - 64'd1);
  localparam logic signed [R_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [P_W-1:0] ROUND_P = P_W'(64'd1 << (GAIN_FRAC - 1));

  // ------------------------------------------------------------------------
  // Configuration register
  // ------------------------------------------------------------------------
  logic                     cfg_wr;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic signed [TEMP_W-1:0] thresh_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= TEMP_W'(THRESH_RST);
    end else if (cfg_wr && reg_idx == REG_THRESH) begin
      thresh_r <= cfg_pwdata[TEMP_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx == REG_THRESH) begin
      cfg_prdata = {{(CFG_DW - TEMP_W){thresh_r[TEMP_W-1]}}, thresh_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  // ------------------------------------------------------------------------
  // Request decode and calibration tables
  // ------------------------------------------------------------------------
  logic                     skid_v_r;
  logic                     en;
  logic                     accept;
  logic                     ch_ok;
  logic [CH_IDX_W-1:0]      ch_idx;
  logic                     load_wr;
  logic                     conv_in;
  logic signed [GAIN_W-1:0] gain_rd;
  logic signed [TEMP_W-1:0] ofs_rd;

  logic signed [GAIN_W-1:0] gain_tbl_r [NUM_CHANNELS];
  logic signed [TEMP_W-1:0] ofs_tbl_r  [NUM_CHANNELS];

  // Whole pipeline advances unless the skid entry is holding a result
  assign en       = ~skid_v_r;
  assign in_ready = en;
  assign accept   = in_valid & in_ready;
  assign ch_ok    = (in_channel < CH_W'(NUM_CHANNELS));
  assign ch_idx   = in_channel[CH_IDX_W-1:0];
  assign load_wr  = accept & ch_ok & (in_operation == OP_LOAD);
  assign conv_in  = accept & ch_ok & (in_operation == OP_CONVERT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        gain_tbl_r[i] <= GAIN_W'(GAIN_UNITY);
        ofs_tbl_r[i]  <= '0;
      end
    end else if (load_wr) begin
      gain_tbl_r[ch_idx] <= in_gain;
      ofs_tbl_r[ch_idx]  <= in_offset;
    end
  end

  // Read calibration for the request entering the pipeline
  always_comb begin
    if (ch_ok) begin
      gain_rd = gain_tbl_r[ch_idx];
      ofs_rd  = ofs_tbl_r[ch_idx];
    end else begin
      gain_rd = '0;
      ofs_rd  = '0;
    end
  end

  // ------------------------------------------------------------------------
  // Valid bits and side-band record
  // ------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  side_t          side_r [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], conv_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{ch: in_channel, gain: gain_rd, offset: ofs_rd};
      for (int i = 1; i < NST; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ------------------------------------------------------------------------
  // Radicand: scale the sample, subtract from the curve constant
  // ------------------------------------------------------------------------
  logic [PROD_W-1:0] prod_r;
  logic [N_W-1:0]    n_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(K1_V) * PROD_W'(in_sample[ADC_BITS-1:0]);
      n_r    <= N_W'(K0_V) - (N_W'(prod_r) << K1_SH);
    end
  end

  // ------------------------------------------------------------------------
  // Square root, one result bit per stage
  // ------------------------------------------------------------------------
  logic [N_W-1:0]     sq_n_r    [SQ_STEPS];
  logic [REM_W-1:0]   sq_rem_r  [SQ_STEPS];
  logic [ROOT_W-1:0]  sq_root_r [SQ_STEPS];
  logic [N_W-1:0]     sq_n_src  [SQ_STEPS];
  logic [REM_W-1:0]   sq_rem_src[SQ_STEPS];
  logic [ROOT_W-1:0]  sq_root_src[SQ_STEPS];
  logic [REM_W+1:0]   sq_trial  [SQ_STEPS];
  logic [REM_W+1:0]   sq_test   [SQ_STEPS];
  logic [SQ_STEPS-1:0] sq_ge;

  always_comb begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      if (j == 0) begin
        sq_n_src[j]    = n_r;
        sq_rem_src[j]  = '0;
        sq_root_src[j] = '0;
      end else begin
        sq_n_src[j]    = sq_n_r[j-1];
        sq_rem_src[j]  = sq_rem_r[j-1];
        sq_root_src[j] = sq_root_r[j-1];
      end
      // Bring down the next two radicand bits, try root*4+1
      sq_trial[j] = {sq_rem_src[j], sq_n_src[j][N_W-1 -: 2]};
      sq_test[j]  = (REM_W + 2)'({sq_root_src[j], 2'b01});
      sq_ge[j]    = (sq_trial[j] >= sq_test[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SQ_STEPS; j++) begin
        sq_n_r[j]    <= sq_n_src[j] << 2;
        sq_root_r[j] <= {sq_root_src[j][ROOT_W-2:0], sq_ge[j]};
        if (sq_ge[j]) begin
          sq_rem_r[j] <= REM_W'(sq_trial[j] - sq_test[j]);
        end else begin
          sq_rem_r[j] <= REM_W'(sq_trial[j]);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Root to temperature: magnitude, reciprocal multiply, correct, sign
  // ------------------------------------------------------------------------
  logic signed [D_W-1:0]  diff;
  logic [D_W-1:0]         absd;
  logic [MAGF_W-1:0]      scaled;
  logic [QP_W-1:0]        qprod;
  logic                   q_up;
  logic [QEST_W:0]        q_fix;

  logic [MAG_W-1:0]       mag1_r, mag2_r, mag3_r;
  logic                   neg1_r, neg2_r, neg3_r;
  logic [QEST_W-1:0]      qest2_r, qest3_r;
  logic [QD_W-1:0]        qd3_r;
  logic signed [T_W-1:0]  t4_r;

  always_comb begin
    diff   = D_W'(T_OFS) - D_W'(sq_root_r[SQ_STEPS-1]);
    absd   = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
    scaled = MAGF_W'(absd) * MAGF_W'(NUM_SCALE) + MAGF_W'(DEN_HALF);
    qprod  = QP_W'(mag1_r) * QP_W'(RECIP);
    q_up   = ({1'b0, MAG_W'(mag3_r)} >= (MAG_W + 1)'(qd3_r) + (MAG_W + 1)'(DEN_SUB));
    q_fix  = (QEST_W + 1)'(qest3_r) + (QEST_W + 1)'(q_up);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Magnitude of the rounded numerator, pre-divided by eight
      mag1_r  <= scaled[MAGF_W-1:DEN_SH];
      neg1_r  <= diff[D_W-1];
      // Quotient estimate, at most one short
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      qest2_r <= qprod[MAG_W +: QEST_W];
      // Back-multiply for the remainder check
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      qest3_r <= qest2_r;
      qd3_r   <= QD_W'(qest2_r) * QD_W'(DEN_SUB);
      // Corrected quotient with the numerator's sign
      if (neg3_r) begin
        t4_r <= -T_W'(q_fix);
      end else begin
        t4_r <= T_W'(q_fix);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Calibration: Q4.12 gain with half-up rounding, then offset
  // ------------------------------------------------------------------------
  logic signed [P_W-1:0] p_r;
  logic signed [P_W-1:0] p_rnd;
  logic signed [P_W-1:0] g_full;
  logic signed [R_W-1:0] r_r;

  always_comb begin
    p_rnd  = p_r + ROUND_P;
    g_full = p_rnd >>> GAIN_FRAC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= P_W'(t4_r) * P_W'($signed(side_r[ST_D4].gain));
      r_r <= R_W'(g_full) + R_W'($signed(side_r[ST_G1].offset));
    end
  end

  // ------------------------------------------------------------------------
  // Saturate, threshold check, output register and skid entry
  // ------------------------------------------------------------------------
  logic                     pv;
  logic signed [TEMP_W-1:0] sat_temp;
  logic                     rd_ok;
  logic                     out_v_r;
  logic [CH_W-1:0]          out_ch_r,   skid_ch_r;
  logic signed [TEMP_W-1:0] out_temp_r, skid_temp_r;
  logic                     out_ok_r,   skid_ok_r;
  logic                     out_load;
  logic                     skid_load;

  assign pv = v_r[NST-1];

  always_comb begin
    if (r_r > SAT_HI) begin
      sat_temp = TEMP_W'(SAT_HI);
    end else if (r_r < SAT_LO) begin
      sat_temp = TEMP_W'(SAT_LO);
    end else begin
      sat_temp = TEMP_W'(r_r);
    end
    rd_ok = (r_r < R_W'(thresh_r));
  end

  assign out_load  = skid_v_r ? out_ready : (pv & (~out_v_r | out_ready));
  assign skid_load = ~skid_v_r & pv & out_v_r & ~out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        // Drain the skid entry into the output register
        if (out_ready) begin
          skid_v_r <= 1'b0;
        end
      end else if (pv) begin
        if (!out_v_r || out_ready) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_v_r) begin
        out_ch_r   <= skid_ch_r;
        out_temp_r <= skid_temp_r;
        out_ok_r   <= skid_ok_r;
      end else begin
        out_ch_r   <= side_r[ST_G2].ch;
        out_temp_r <= sat_temp;
        out_ok_r   <= rd_ok;
      end
    end
    if (skid_load) begin
      skid_ch_r   <= side_r[ST_G2].ch;
      skid_temp_r <= sat_temp;
      skid_ok_r   <= rd_ok;
    end
  end

  assign out_valid         = out_v_r;
  assign out_channel       = out_ch_r;
  assign out_temperature   = out_temp_r;
  assign out_reading_valid = out_ok_r;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  // Skid entry only holds a result behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid while output register empty");

  // A load request never enters the datapath
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_LOAD) |=> !v_r[0])
    else $error("load request entered the pipeline");

  // A result leaves the output only when the consumer takes it
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_v_r) |-> $past(out_ready))
    else $error("result dropped without being taken");

  // A load updates the addressed gain entry
  a_load_writes: assert property (@(posedge clk) disable iff (!rst_n)
    load_wr |=> gain_tbl_r[$past(ch_idx)] == $past(in_gain))
    else $error("calibration load not written");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench: RTD temperature unit checker
// Drives convert and calibration-load requests through the valid/ready input,
// predicts each calibrated temperature with an independent integer model of
// the square-root curve inversion, gain and offset, and compares every result
// in order. The threshold register is swept over its extremes through APB.
// ============================================================================

module testbench;
  import rtdat_pkg::*;

  // Sensor curve coefficients, scaled as in the fixed-point definition
  localparam longint unsigned CURVE_A    = 60154;
  localparam longint unsigned CURVE_B    = 94526;
  localparam longint unsigned CURVE_C    = 20988;
  localparam int              CURVE_FRAC = 22;
  localparam longint          TEMP_MAX   = (64'sd1 <<< (TEMP_W - 1)) - 1;
  localparam longint          TEMP_MIN   = -(64'sd1 <<< (TEMP_W - 1));
  localparam int              SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  localparam int LATENCY_CYCLES = 40;
  localparam int SETTLE_LIMIT   = 20000;
  localparam int PRINT_LIMIT    = 30;

  localparam logic [CFG_AW-1:0] THRESH_ADDR   = {REG_THRESH, 2'b00};
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = {REG_IDX_W'(1), 2'b00};

  typedef struct {
    logic        [CH_W-1:0]   channel;
    logic signed [TEMP_W-1:0] temperature;
    logic                     reading_valid;
  } reading_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic                      in_operation = OP_CONVERT;
  logic        [CH_W-1:0]    in_channel   = '0;
  logic        [SAMPLE_W-1:0] in_sample   = '0;
  logic signed [GAIN_W-1:0]  in_gain      = '0;
  logic signed [TEMP_W-1:0]  in_offset    = '0;

  logic                      out_valid;
  logic                      out_ready    = 1'b1;
  logic        [CH_W-1:0]    out_channel;
  logic signed [TEMP_W-1:0]  out_temperature;
  logic                      out_reading_valid;

  logic                      cfg_psel    = 1'b0;
  logic                      cfg_penable = 1'b0;
  logic                      cfg_pwrite  = 1'b0;
  logic        [CFG_AW-1:0]  cfg_paddr   = '0;
  logic        [CFG_DW-1:0]  cfg_pwdata  = '0;
  logic        [CFG_DW-1:0]  cfg_prdata;
  logic                      cfg_pready;

  // Predictor state: calibration tables and threshold as the unit should hold them
  logic signed [GAIN_W-1:0] gain_cal   [NUM_CHANNELS];
  logic signed [TEMP_W-1:0] offset_cal [NUM_CHANNELS];
  logic signed [TEMP_W-1:0] alarm_threshold = TEMP_W'(THRESH_RST);

  reading_t expected_readings[$];
  reading_t next_reading;
  int       fail_count    = 0;
  int       results_seen  = 0;
  int       burst_left    = 0;
  int       sink_hold     = 0;
  int       sink_phase    = 0;
  sink_mode_t sink_mode   = SINK_OPEN;

  rtd_adc_to_temperature_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_channel        (in_channel),
    .in_sample         (in_sample),
    .in_gain           (in_gain),
    .in_offset         (in_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel       (out_channel),
    .out_temperature   (out_temperature),
    .out_reading_valid (out_reading_valid),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Invert the sensor curve: code -> uncalibrated temperature in 1/256 C
  function automatic longint degrees_from_code(input logic [SAMPLE_W-1:0] code);
    longint unsigned radicand;
    longint unsigned root;
    longint unsigned trial;
    longint          numer;
    longint          denom;
    radicand = ((100 * CURVE_B * CURVE_B + 4 * CURVE_A * CURVE_C) << CURVE_FRAC)
             - ((13200000 * CURVE_A * code) << (CURVE_FRAC - ADC_BITS));
    root = 0;
    for (int i = 30; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= radicand) root = trial;
    end
    numer = (longint'(20480 * CURVE_B) - longint'(root)) * 25;
    denom = longint'(4 * CURVE_A);
    // round half away from zero
    if (numer >= 0) return (numer + denom / 2) / denom;
    return -((-numer + denom / 2) / denom);
  endfunction

  // Apply gain, offset, saturation and the disconnect check
  function automatic reading_t predict_reading(input logic [CH_W-1:0] ch,
                                               input logic [SAMPLE_W-1:0] code);
    longint   raw;
    longint   scaled;
    longint   total;
    reading_t rd;
    raw    = degrees_from_code(code);
    scaled = (longint'(gain_cal[ch]) * raw + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    total  = scaled + longint'(offset_cal[ch]);
    rd.channel = ch;
    if (total > TEMP_MAX)      rd.temperature = TEMP_MAX[TEMP_W-1:0];
    else if (total < TEMP_MIN) rd.temperature = TEMP_MIN[TEMP_W-1:0];
    else                       rd.temperature = total[TEMP_W-1:0];
    rd.reading_valid = (total < longint'(alarm_threshold));
    return rd;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < PRINT_LIMIT)
      $display("MISMATCH %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    fail_count++;
  endtask

  // Send one request in bursts with random idle gaps; predict on acceptance
  task automatic send_request(input logic op, input logic [CH_W-1:0] ch,
                              input logic [SAMPLE_W-1:0] code,
                              input logic signed [GAIN_W-1:0] gain,
                              input logic signed [TEMP_W-1:0] offset);
    int idle_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25) : $urandom_range(0, 2);
      if (idle_len > 0) begin
        in_valid <= 1'b0;
        repeat (idle_len) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_channel   <= ch;
    in_sample    <= code;
    in_gain      <= gain;
    in_offset    <= offset;
    do @(posedge clk); while (!in_ready);
    if (ch < NUM_CHANNELS) begin
      if (op == OP_LOAD) begin
        gain_cal[ch]   = gain;
        offset_cal[ch] = offset;
      end else begin
        expected_readings.push_back(predict_reading(ch, code));
      end
    end
  endtask

  // Hold off requests until every pending result is in, then let loads flush
  task automatic settle_pipeline();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_readings.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_readings.size() != 0) begin
      report_mismatch("results never arrived", 0, expected_readings.size());
      expected_readings.delete();
    end
    repeat (LATENCY_CYCLES + 8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == THRESH_ADDR) alarm_threshold = data[TEMP_W-1:0];
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [CFG_AW-1:0] addr, output logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the threshold and confirm it reads back
  task automatic set_threshold(input int value);
    logic [CFG_DW-1:0] readback;
    apb_write(THRESH_ADDR, CFG_DW'(value));
    apb_read(THRESH_ADDR, readback);
    if (readback[TEMP_W-1:0] !== alarm_threshold)
      report_mismatch("threshold readback", readback[TEMP_W-1:0], alarm_threshold);
  endtask

  // Random request: mostly converts on valid channels, some loads and bad channels
  task automatic send_random_request();
    logic                     op;
    logic        [CH_W-1:0]   ch;
    logic        [SAMPLE_W-1:0] code;
    logic signed [GAIN_W-1:0] gain;
    logic signed [TEMP_W-1:0] offset;
    op = ($urandom_range(0, 7) == 0) ? OP_LOAD : OP_CONVERT;
    ch = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(NUM_CHANNELS, 15))
                                     : CH_W'($urandom_range(0, NUM_CHANNELS - 1));
    case ($urandom_range(0, 9))
      0:       code = SAMPLE_W'($urandom_range(0, 15));
      1:       code = SAMPLE_W'($urandom_range(SAMPLE_MAX - 15, SAMPLE_MAX));
      default: code = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endcase
    case ($urandom_range(0, 4))
      0, 1: gain = GAIN_W'(GAIN_UNITY + int'($urandom_range(0, 800)) - 400);
      2: begin
        case ($urandom_range(0, 3))
          0:       gain = {1'b0, {(GAIN_W-1){1'b1}}};
          1:       gain = {1'b1, {(GAIN_W-1){1'b0}}};
          2:       gain = '0;
          default: gain = '1;
        endcase
      end
      default: gain = GAIN_W'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0, 1: offset = ($urandom_range(0, 1) == 1) ? {1'b0, {(TEMP_W-1){1'b1}}}
                                                : {1'b1, {(TEMP_W-1){1'b0}}};
      2, 3, 4: offset = TEMP_W'($urandom());
      default: offset = TEMP_W'(int'($urandom_range(0, 131072)) - 65536);
    endcase
    send_request(op, ch, code, gain, offset);
  endtask

  // Reset calibration on channels 0 to 3, 7 and 11, sample extremes and bit patterns
  task automatic test_reset_calibration();
    send_request(OP_CONVERT, 4'd0,  12'd0,          '0, '0);
    send_request(OP_CONVERT, 4'd1,  SAMPLE_W'(SAMPLE_MAX), '0, '0);
    send_request(OP_CONVERT, 4'd2,  12'hAAA,        '0, '0);
    send_request(OP_CONVERT, 4'd3,  12'h555,        '0, '0);
    send_request(OP_CONVERT, 4'd7,  12'h800,        '0, '0);
    send_request(OP_CONVERT, 4'd11, 12'd1,          '0, '0);
  endtask

  // Channels at or above the table size: loads ignored, converts dropped
  task automatic test_channel_bounds();
    send_request(OP_CONVERT, 4'd12, 12'd100,        '0, '0);
    send_request(OP_CONVERT, 4'd15, SAMPLE_W'(SAMPLE_MAX), '1, '1);
    send_request(OP_LOAD,    4'd12, 12'd0,          '1, '1);
    send_request(OP_LOAD,    4'd15, 12'd0,          '0, {1'b0, {(TEMP_W-1){1'b1}}});
    send_request(OP_CONVERT, 4'd11, SAMPLE_W'(SAMPLE_MAX), '0, '0);
    send_request(OP_CONVERT, 4'd0,  12'd2048,       '0, '0);
  endtask

  // Gain and offset extremes: saturate high and low, zero and minus-one gains
  task automatic test_calibration_extremes();
    send_request(OP_LOAD,    4'd3, 12'd0, {1'b0, {(GAIN_W-1){1'b1}}},
                 {1'b0, {(TEMP_W-1){1'b1}}});
    send_request(OP_CONVERT, 4'd3, SAMPLE_W'(SAMPLE_MAX), '0, '0);
    send_request(OP_CONVERT, 4'd3, 12'd0, '0, '0);
    send_request(OP_LOAD,    4'd4, 12'd0, {1'b1, {(GAIN_W-1){1'b0}}},
                 {1'b1, {(TEMP_W-1){1'b0}}});
    send_request(OP_CONVERT, 4'd4, SAMPLE_W'(SAMPLE_MAX), '0, '0);
    send_request(OP_CONVERT, 4'd4, 12'd0, '0, '0);
    send_request(OP_LOAD,    4'd5, 12'd0, '0, '0);
    send_request(OP_CONVERT, 4'd5, 12'd3000, '0, '0);
    send_request(OP_LOAD,    4'd6, 12'd0, '1, '1);
    send_request(OP_CONVERT, 4'd6, 12'd0, '0, '0);
    send_request(OP_CONVERT, 4'd6, SAMPLE_W'(SAMPLE_MAX), '0, '0);
  endtask

  // Sweep the threshold over its extremes; an unmapped write must not touch it
  task automatic test_threshold_settings();
    int settings[5];
    settings = '{int'(TEMP_MIN), int'(TEMP_MAX), 0, 64 * 256, THRESH_RST};
    foreach (settings[k]) begin
      settle_pipeline();
      set_threshold(settings[k]);
      if (k == 2) apb_write(UNMAPPED_ADDR, CFG_DW'(TEMP_MAX));
      repeat (30) send_random_request();
    end
  endtask

  // Long random run with a full drain and threshold change every 300 requests
  task automatic test_random_traffic();
    for (int n = 0; n < 1200; n++) begin
      if (n % 300 == 150) begin
        settle_pipeline();
        if ($urandom_range(0, 1) == 1) set_threshold($urandom_range(0, 140000));
        else                           set_threshold(int'(TEMP_W'($urandom())));
      end
      send_random_request();
    end
  endtask

  // Result-side stall pattern: switch to a random mode after a random hold
  always @(posedge clk) begin
    if (sink_hold == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_hold = $urandom_range(50, 300);
    end else begin
      sink_hold--;
    end
    sink_phase++;
    case (sink_mode)
      SINK_OPEN:     out_ready <= 1'b1;
      SINK_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
      SINK_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
      SINK_PERIODIC: out_ready <= ((sink_phase % 5) < 2);
    endcase
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("result with nothing pending", out_temperature, 0);
      end else begin
        next_reading = expected_readings.pop_front();
        if (out_channel !== next_reading.channel)
          report_mismatch("channel", out_channel, next_reading.channel);
        if (out_temperature !== next_reading.temperature)
          report_mismatch("temperature", out_temperature, next_reading.temperature);
        if (out_reading_valid !== next_reading.reading_valid)
          report_mismatch("reading_valid", out_reading_valid, next_reading.reading_valid);
      end
      results_seen++;
    end
  end

  initial begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      gain_cal[c]   = GAIN_W'(GAIN_UNITY);
      offset_cal[c] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_calibration();
    test_channel_bounds();
    test_calibration_extremes();
    test_threshold_settings();
    test_random_traffic();
    settle_pipeline();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
